@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define POT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every clock edge, reset included
`define POT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/pot_pkg.sv @@
package pot_pkg;

  // master cell size writes take the low 31 bits of the data
  localparam int unsigned SIZE_WIDTH    = 31;
  localparam int unsigned CFG_IDX_WIDTH = 3;

  typedef enum logic [2:0] {
    ORIENT_N  = 3'd0,
    ORIENT_W  = 3'd1,
    ORIENT_S  = 3'd2,
    ORIENT_E  = 3'd3,
    ORIENT_FN = 3'd4,
    ORIENT_FE = 3'd5,
    ORIENT_FS = 3'd6,
    ORIENT_FW = 3'd7
  } orient_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_ORIENT   = 3'd0,
    CFG_PLACE_X  = 3'd1,
    CFG_PLACE_Y  = 3'd2,
    CFG_ORIGIN_X = 3'd3,
    CFG_ORIGIN_Y = 3'd4,
    CFG_WIDTH    = 3'd5,
    CFG_HEIGHT   = 3'd6,
    CFG_PIN_MODE = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    CMD_POINT = 1'b0,
    CMD_BOX   = 1'b1
  } cmd_e;

  // control handed from the configuration block to the datapath
  typedef struct packed {
    orient_e orient;
    logic    pin_mode;
  } ctrl_t;

endpackage

@@ src/pot_in_if.sv @@
interface pot_in_if #(
  parameter int unsigned CoordWidth = 32
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [CoordWidth-1:0] in_x0;
  logic signed [CoordWidth-1:0] in_y0;
  logic signed [CoordWidth-1:0] in_x1;
  logic signed [CoordWidth-1:0] in_y1;

  modport source (output valid, command, in_x0, in_y0, in_x1, in_y1, input ready);
  modport sink   (input valid, command, in_x0, in_y0, in_x1, in_y1, output ready);
endinterface

@@ src/pot_out_if.sv @@
interface pot_out_if #(
  parameter int unsigned CoordWidth = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] out_x0;
  logic signed [CoordWidth-1:0] out_y0;
  logic signed [CoordWidth-1:0] out_x1;
  logic signed [CoordWidth-1:0] out_y1;

  modport source (output valid, out_x0, out_y0, out_x1, out_y1, input ready);
  modport sink   (input valid, out_x0, out_y0, out_x1, out_y1, output ready);
endinterface

@@ src/placement_orientation_transform.sv @@
// placement orientation transform
// in_if carries one point or box per beat (command, in_x0/in_y0, in_x1/in_y1);
// out_if returns exactly one result beat for each input beat, in order.
// the configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) sets orientation,
// location, cell origin, cell size and pin mode; write it only while idle.
// a write is taken on any edge with cfg_we_i high; unknown indexes are dropped.
// the placement offset is precomputed into a register in the cycle after a write.
// an accepted beat moves from the input register to the output register, which
// drives out_if.valid; a stalled out_if can hold it in the input register.
// throughput: one beat per cycle while out_if takes its beats, set by the input
// register and the output register with one add and one signed compare between them.
// a stalled out_if holds its beat; the input register keeps taking a beat as
// long as the output register is free or drains in the same cycle.
// reset clears both valid bits and sets the configuration registers to zero (north,
// instance mode, zero location, origin and size).
`include "assert_macros.svh"

module placement_orientation_transform #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pot_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [((COORD_WIDTH > pot_pkg::SIZE_WIDTH) ?
                 COORD_WIDTH : pot_pkg::SIZE_WIDTH)-1:0] cfg_data_i,
  pot_in_if.sink                            in_if,
  pot_out_if.source                         out_if
);

  localparam int unsigned CfgWidth =
    (COORD_WIDTH > pot_pkg::SIZE_WIDTH) ? COORD_WIDTH : pot_pkg::SIZE_WIDTH;

  pot_pkg::ctrl_t           ctrl;
  logic [COORD_WIDTH-1:0]   off_x, off_y;

  // placement registers and offset register
  pot_cfg #(
    .CoordWidth (COORD_WIDTH),
    .CfgWidth   (CfgWidth)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_o     (ctrl),
    .off_x_o    (off_x),
    .off_y_o    (off_y)
  );

  // input register
  logic                          s1_valid_q;
  logic                          s1_cmd_q;
  logic signed [COORD_WIDTH-1:0] s1_x0_q, s1_y0_q, s1_x1_q, s1_y1_q;
  logic                          in_fire, s2_load;

  // output register
  logic                          out_valid_q;
  logic                          box_q;
  logic signed [COORD_WIDTH-1:0] out_x0_q, out_y0_q, out_x1_q, out_y1_q;
  logic signed [COORD_WIDTH-1:0] out_x0_d, out_y0_d, out_x1_d, out_y1_d;

  // output stage is free when empty or drained this cycle
  assign s2_load     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || s2_load;
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s2_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q <= in_if.command;
      s1_x0_q  <= in_if.in_x0;
      s1_y0_q  <= in_if.in_y0;
      s1_x1_q  <= in_if.in_x1;
      s1_y1_q  <= in_if.in_y1;
    end
  end

  // both corners mapped in parallel
  logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;

  pot_corner #(.CoordWidth (COORD_WIDTH)) u_corner_a (
    .orient_i (ctrl.orient),
    .off_x_i  (off_x),
    .off_y_i  (off_y),
    .x_i      (s1_x0_q),
    .y_i      (s1_y0_q),
    .x_o      (ax),
    .y_o      (ay)
  );

  pot_corner #(.CoordWidth (COORD_WIDTH)) u_corner_b (
    .orient_i (ctrl.orient),
    .off_x_i  (off_x),
    .off_y_i  (off_y),
    .x_i      (s1_x1_q),
    .y_i      (s1_y1_q),
    .x_o      (bx),
    .y_o      (by)
  );

  // a point leaves the upper corner at zero; a box is sorted per axis
  always_comb begin
    out_x0_d = ax;
    out_y0_d = ay;
    out_x1_d = '0;
    out_y1_d = '0;
    if (s1_cmd_q == pot_pkg::CMD_BOX) begin
      if (ax < bx) begin
        out_x0_d = ax;
        out_x1_d = bx;
      end else begin
        out_x0_d = bx;
        out_x1_d = ax;
      end
      if (ay < by) begin
        out_y0_d = ay;
        out_y1_d = by;
      end else begin
        out_y0_d = by;
        out_y1_d = ay;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      box_q    <= (s1_cmd_q == pot_pkg::CMD_BOX);
      out_x0_q <= out_x0_d;
      out_y0_q <= out_y0_d;
      out_x1_q <= out_x1_d;
      out_y1_q <= out_y1_d;
    end
  end

  assign out_if.valid  = out_valid_q;
  assign out_if.out_x0 = out_x0_q;
  assign out_if.out_y0 = out_y0_q;
  assign out_if.out_x1 = out_x1_q;
  assign out_if.out_y1 = out_y1_q;

  `POT_ASSERT(a_box_x_sorted, out_valid_q && box_q |-> out_x0_q <= out_x1_q,
    "box result x not in low to high order")
  `POT_ASSERT(a_box_y_sorted, out_valid_q && box_q |-> out_y0_q <= out_y1_q,
    "box result y not in low to high order")
  `POT_ASSERT(a_point_upper_zero,
    out_valid_q && !box_q |-> out_x1_q == '0 && out_y1_q == '0,
    "point result has a non-zero upper corner")
  `POT_ASSERT(a_stage_hold, s1_valid_q && !s2_load |=> s1_valid_q,
    "pending beat dropped from the input register")
  `POT_ASSERT(a_stage_move, s1_valid_q && s2_load |=> out_valid_q,
    "beat moved on but no result appeared")
  `POT_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_q && !s1_valid_q,
    "pipeline not empty in reset")

endmodule

@@ src/pot_cfg.sv @@
`include "assert_macros.svh"

module pot_cfg #(
  parameter int unsigned CoordWidth = 32,
  parameter int unsigned CfgWidth   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pot_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  logic [CfgWidth-1:0]                 cfg_data_i,
  output pot_pkg::ctrl_t                      ctrl_o,
  output logic [CoordWidth-1:0]               off_x_o,
  output logic [CoordWidth-1:0]               off_y_o
);

  logic [CoordWidth-1:0] place_x_q, place_y_q;
  logic [CoordWidth-1:0] ox_q, oy_q;
  logic [CoordWidth-1:0] w_q, h_q;
  logic [CoordWidth-1:0] oxw_q, oyh_q;
  pot_pkg::ctrl_t        ctrl_q;
  logic [CoordWidth-1:0] off_x_q, off_y_q;
  logic [CoordWidth-1:0] off_x_d, off_y_d;

  logic [CoordWidth-1:0]          data_c;
  logic [CfgWidth-1:0]            size_wide;
  logic [CoordWidth-1:0]          size_c;

  assign data_c    = cfg_data_i[CoordWidth-1:0];
  // size is 31 bits, then wraps at coordinate width
  assign size_wide = CfgWidth'(cfg_data_i[pot_pkg::SIZE_WIDTH-1:0]);
  assign size_c    = size_wide[CoordWidth-1:0];

  // configuration registers; origin plus size sums kept up to date on every write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      place_x_q <= '0;
      place_y_q <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
      w_q       <= '0;
      h_q       <= '0;
      oxw_q     <= '0;
      oyh_q     <= '0;
      ctrl_q    <= '{orient: pot_pkg::ORIENT_N, pin_mode: 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pot_pkg::CFG_ORIENT: begin
          ctrl_q.orient <= pot_pkg::orient_e'(cfg_data_i[2:0]);
        end
        pot_pkg::CFG_PLACE_X: begin
          place_x_q <= data_c;
        end
        pot_pkg::CFG_PLACE_Y: begin
          place_y_q <= data_c;
        end
        pot_pkg::CFG_ORIGIN_X: begin
          ox_q  <= data_c;
          oxw_q <= data_c + w_q;
        end
        pot_pkg::CFG_ORIGIN_Y: begin
          oy_q  <= data_c;
          oyh_q <= data_c + h_q;
        end
        pot_pkg::CFG_WIDTH: begin
          w_q   <= size_c;
          oxw_q <= ox_q + size_c;
        end
        pot_pkg::CFG_HEIGHT: begin
          h_q   <= size_c;
          oyh_q <= oy_q + size_c;
        end
        pot_pkg::CFG_PIN_MODE: begin
          ctrl_q.pin_mode <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    off_x_d = place_x_q;
    off_y_d = place_y_q;
    if (!ctrl_q.pin_mode) begin
      case (ctrl_q.orient)
        pot_pkg::ORIENT_N: begin
          off_x_d = place_x_q - ox_q;
          off_y_d = place_y_q - oy_q;
        end
        pot_pkg::ORIENT_W: begin
          off_x_d = place_x_q + oyh_q;
          off_y_d = place_y_q - ox_q;
        end
        pot_pkg::ORIENT_S: begin
          off_x_d = place_x_q + oxw_q;
          off_y_d = place_y_q + oyh_q;
        end
        pot_pkg::ORIENT_E: begin
          off_x_d = place_x_q - oy_q;
          off_y_d = place_y_q + oxw_q;
        end
        pot_pkg::ORIENT_FN: begin
          off_x_d = place_x_q + oxw_q;
          off_y_d = place_y_q - oy_q;
        end
        pot_pkg::ORIENT_FE: begin
          off_x_d = place_x_q + oyh_q;
          off_y_d = place_y_q + oxw_q;
        end
        pot_pkg::ORIENT_FS: begin
          off_x_d = place_x_q - ox_q;
          off_y_d = place_y_q + oyh_q;
        end
        default: begin
          off_x_d = place_x_q - oy_q;
          off_y_d = place_y_q - ox_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
    end else begin
      off_x_q <= off_x_d;
      off_y_q <= off_y_d;
    end
  end

  assign ctrl_o  = ctrl_q;
  assign off_x_o = off_x_q;
  assign off_y_o = off_y_q;

  `POT_ASSERT(a_pin_offset_x, ctrl_q.pin_mode |=> off_x_q == $past(place_x_q),
    "pin mode offset x is not the location")
  `POT_ASSERT(a_pin_offset_y, ctrl_q.pin_mode |=> off_y_q == $past(place_y_q),
    "pin mode offset y is not the location")
  `POT_ASSERT(a_width_sum, cfg_we_i && cfg_idx_i == pot_pkg::CFG_WIDTH |=>
    oxw_q == ox_q + w_q, "origin plus width sum out of step")

endmodule

@@ src/pot_corner.sv @@
module pot_corner #(
  parameter int unsigned CoordWidth = 32
) (
  input  pot_pkg::orient_e      orient_i,
  input  logic [CoordWidth-1:0] off_x_i,
  input  logic [CoordWidth-1:0] off_y_i,
  input  logic [CoordWidth-1:0] x_i,
  input  logic [CoordWidth-1:0] y_i,
  output logic [CoordWidth-1:0] x_o,
  output logic [CoordWidth-1:0] y_o
);

  logic                  swap, neg_a, neg_b;
  logic [CoordWidth-1:0] a, b;

  always_comb begin
    swap  = 1'b0;
    neg_a = 1'b0;
    neg_b = 1'b0;
    case (orient_i)
      pot_pkg::ORIENT_N:  begin end
      pot_pkg::ORIENT_W:  begin swap = 1'b1; neg_a = 1'b1; end
      pot_pkg::ORIENT_S:  begin neg_a = 1'b1; neg_b = 1'b1; end
      pot_pkg::ORIENT_E:  begin swap = 1'b1; neg_b = 1'b1; end
      pot_pkg::ORIENT_FN: begin neg_a = 1'b1; end
      pot_pkg::ORIENT_FE: begin swap = 1'b1; neg_a = 1'b1; neg_b = 1'b1; end
      pot_pkg::ORIENT_FS: begin neg_b = 1'b1; end
      default:            begin swap = 1'b1; end
    endcase
  end

  assign a = swap ? y_i : x_i;
  assign b = swap ? x_i : y_i;

  // negation folds into the offset add
  assign x_o = neg_a ? (off_x_i - a) : (off_x_i + a);
  assign y_o = neg_b ? (off_y_i - b) : (off_y_i + b);

endmodule
